// ===== rtl/sbp_pkg.sv =====
// Shared types and constants for the six-button pad select responder.
package sbp_pkg;

  localparam int unsigned TIMER_BITS_DEFAULT = 16;

  localparam int unsigned PAD_W      = 16;
  localparam int unsigned LINES_W    = 6;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned LAYOUT_W   = 2;
  localparam int unsigned TIMEOUT_W  = 16;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd4096;
  localparam logic [PAD_W-1:0]     BUTTONS_IDLE  = 16'hFFFF;

  // Word kinds on the input channel.
  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_TICK   = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_BUTTON_LAYOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

  // Button layouts.
  localparam logic [LAYOUT_W-1:0] LAYOUT_BC_JUMP = 2'd0;
  localparam logic [LAYOUT_W-1:0] LAYOUT_AB_JUMP = 2'd1;
  localparam logic [LAYOUT_W-1:0] LAYOUT_ALT     = 2'd2;

  // Bit positions in the pad word.
  localparam int unsigned PAD_B      = 15;
  localparam int unsigned PAD_Y      = 14;
  localparam int unsigned PAD_SELECT = 13;
  localparam int unsigned PAD_START  = 12;
  localparam int unsigned PAD_UP     = 11;
  localparam int unsigned PAD_DOWN   = 10;
  localparam int unsigned PAD_LEFT   = 9;
  localparam int unsigned PAD_RIGHT  = 8;
  localparam int unsigned PAD_A      = 7;
  localparam int unsigned PAD_X      = 6;
  localparam int unsigned PAD_L      = 5;
  localparam int unsigned PAD_R      = 4;

  // Layout-mapped face buttons.
  typedef struct packed {
    logic a;
    logic b;
    logic c;
    logic x;
    logic y;
    logic z;
  } face_t;

endpackage

// ===== rtl/six_button_pad_select_responder.sv =====
// Top level of the six-button pad select responder.
// Takes one word per cycle (select sample or timer tick) and answers a sample
// that matches the current phase's expected select level with one registered
// result word; the phase counter and timeout counter update in the same cycle,
// so back-to-back words run at one per clock. A registered output stage holds
// the result; the input stalls only while that stage is full and not being
// taken. Wrong-level samples and ticks produce no result. Configuration
// writes are taken every cycle.
module six_button_pad_select_responder #(
  parameter int unsigned TIMER_BITS = sbp_pkg::TIMER_BITS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            kind,
  input  logic                            select_level,
  input  logic [sbp_pkg::PAD_W-1:0]       pad_buttons,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [sbp_pkg::LINES_W-1:0]     data_lines,
  output logic [sbp_pkg::PHASE_W-1:0]     phase_served,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [sbp_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbp_pkg::TIMEOUT_W-1:0]   cfg_data
);

  localparam int unsigned CMP_W =
    (TIMER_BITS > sbp_pkg::TIMEOUT_W) ? TIMER_BITS : sbp_pkg::TIMEOUT_W;
  localparam logic [TIMER_BITS-1:0] COUNT_MAX = '1;

  logic [sbp_pkg::LAYOUT_W-1:0]  button_layout;
  logic [sbp_pkg::TIMEOUT_W-1:0] timeout_ticks;
  logic [sbp_pkg::PHASE_W-1:0]   phase;
  logic                          timer_armed;
  logic [TIMER_BITS-1:0]         timer_count;
  logic [sbp_pkg::PAD_W-1:0]     latched_buttons;
  logic                          poll_pending;

  logic                          in_fire;
  logic                          serve;
  logic                          tick;
  logic [TIMER_BITS-1:0]         count_inc;
  logic                          expire;
  logic [sbp_pkg::LINES_W-1:0]   lines;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid || out_ready;
  assign in_fire   = in_valid && in_ready;
  // odd phases wait for select low, even phases for select high
  assign serve     = in_fire && (kind == sbp_pkg::KIND_SAMPLE) &&
                     (select_level == !phase[0]);
  assign tick      = in_fire && (kind == sbp_pkg::KIND_TICK);

  assign count_inc = (timer_count == COUNT_MAX) ? timer_count
                                                : timer_count + 1'b1;
  assign expire    = timer_armed &&
                     ((CMP_W'(count_inc) >= CMP_W'(timeout_ticks)) ||
                      (count_inc == COUNT_MAX));

  sbp_entry u_entry (
    .phase   (phase),
    .buttons (latched_buttons),
    .layout  (button_layout),
    .lines   (lines)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      button_layout <= sbp_pkg::LAYOUT_BC_JUMP;
      timeout_ticks <= sbp_pkg::TIMEOUT_RESET;
    end else if (cfg_valid) begin
      case (cfg_index)
        sbp_pkg::CFG_BUTTON_LAYOUT: button_layout <= cfg_data[sbp_pkg::LAYOUT_W-1:0];
        sbp_pkg::CFG_TIMEOUT_TICKS: timeout_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= '0;
      timer_armed     <= 1'b0;
      timer_count     <= '0;
      latched_buttons <= sbp_pkg::BUTTONS_IDLE;
      poll_pending    <= 1'b1;
    end else if (tick) begin
      if (poll_pending) begin
        latched_buttons <= pad_buttons;
        poll_pending    <= 1'b0;
      end
      if (expire) begin
        // drop back to phase 0 and take a fresh pad word
        phase           <= '0;
        timer_armed     <= 1'b0;
        timer_count     <= '0;
        latched_buttons <= pad_buttons;
      end else if (timer_armed) begin
        timer_count <= count_inc;
      end
    end else if (serve) begin
      if (phase != '0) begin
        timer_armed <= 1'b1;
        timer_count <= '0;
      end
      phase <= phase + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= serve;
    end
  end

  always_ff @(posedge clk) begin
    if (serve) begin
      data_lines   <= lines;
      phase_served <= phase;
    end
  end

`ifndef NO_ASSERTIONS
  a_serve_result: assert property (@(posedge clk) disable iff (rst)
    serve |=> out_valid && phase_served == $past(phase))
    else $error("served sample did not yield a result for its phase");

  a_idle_timer_clear: assert property (@(posedge clk) disable iff (rst)
    !timer_armed |-> timer_count == '0)
    else $error("disarmed timer holds a nonzero count");

  a_phase5_lines: assert property (@(posedge clk) disable iff (rst)
    out_valid && phase_served == 3'd5 |-> data_lines[3:0] == 4'b0000)
    else $error("phase 5 entry must drive D0..D3 low");

  a_poll_once: assert property (@(posedge clk) disable iff (rst)
    $fell(poll_pending) |-> $past(tick))
    else $error("poll latch cleared without a tick");

  a_expire_phase0: assert property (@(posedge clk) disable iff (rst)
    tick && expire |=> phase == '0 && !timer_armed)
    else $error("timeout did not return to phase 0");
`endif

endmodule

// ===== rtl/sbp_entry.sv =====
// Schedule entry: maps the latched pad word to the six data lines of a phase.
module sbp_entry (
  input  logic [sbp_pkg::PHASE_W-1:0]  phase,
  input  logic [sbp_pkg::PAD_W-1:0]    buttons,
  input  logic [sbp_pkg::LAYOUT_W-1:0] layout,
  output logic [sbp_pkg::LINES_W-1:0] lines
);

  sbp_pkg::face_t face;
  logic up, down, left, right, start, mode;

  assign up    = buttons[sbp_pkg::PAD_UP];
  assign down  = buttons[sbp_pkg::PAD_DOWN];
  assign left  = buttons[sbp_pkg::PAD_LEFT];
  assign right = buttons[sbp_pkg::PAD_RIGHT];
  assign start = buttons[sbp_pkg::PAD_START];
  assign mode  = buttons[sbp_pkg::PAD_SELECT];

  always_comb begin
    case (layout)
      sbp_pkg::LAYOUT_AB_JUMP: begin
        face.a = buttons[sbp_pkg::PAD_Y];
        face.b = buttons[sbp_pkg::PAD_B];
        face.c = buttons[sbp_pkg::PAD_A];
        face.x = buttons[sbp_pkg::PAD_L];
        face.y = buttons[sbp_pkg::PAD_X];
        face.z = buttons[sbp_pkg::PAD_R];
      end
      sbp_pkg::LAYOUT_ALT: begin
        face.a = buttons[sbp_pkg::PAD_B];
        face.b = buttons[sbp_pkg::PAD_A];
        face.c = buttons[sbp_pkg::PAD_R];
        face.x = buttons[sbp_pkg::PAD_Y];
        face.y = buttons[sbp_pkg::PAD_X];
        face.z = buttons[sbp_pkg::PAD_L];
      end
      default: begin
        // unused code 3 falls back to the default layout
        face.a = buttons[sbp_pkg::PAD_A];
        face.b = buttons[sbp_pkg::PAD_Y];
        face.c = buttons[sbp_pkg::PAD_B];
        face.x = buttons[sbp_pkg::PAD_L];
        face.y = buttons[sbp_pkg::PAD_X];
        face.z = buttons[sbp_pkg::PAD_R];
      end
    endcase
  end

  // Lines are packed D5 down to D0.
  always_comb begin
    case (phase)
      3'd1, 3'd3: lines = {start, face.a, 1'b0, 1'b0, down, up};
      3'd5:       lines = {start, face.a, 4'b0000};
      3'd6:       lines = {face.c, face.b, mode, face.x, face.y, face.z};
      3'd7:       lines = {start, face.a, 4'b1111};
      default:    lines = {face.c, face.b, right, left, down, up};
    endcase
  end

endmodule
